[rtl/core/hde_pkg.sv]
`timescale 1ns / 1ps

package hde_pkg;

    // Date part geometry
    localparam int DATE_LEN = 21;
    localparam int POS_W    = 5;
    localparam int LEN_1123 = 21;
    localparam int LEN_850  = 19;
    localparam int LEN_ASC  = 20;
    localparam int SECS_W   = 38;
    localparam int YEAR_W   = 13;

    // Calendar constants (years counted from 1900, days shifted to March)
    localparam int EPOCH_DAYS = 25508;
    localparam int MIN_YEAR   = 70;
    localparam int CLAMP_YEAR = 138;
    localparam int MIN_CENT   = 19;
    localparam int MAX_MDAY   = 31;
    localparam int LEAP_MDAY  = 29;
    localparam int MAX_HOUR   = 23;
    localparam int MAX_MIN    = 59;
    localparam int MAX_SEC    = 61;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_END   = 8'h2A;

    // Mask class codes
    localparam logic [7:0] CLS_UPPER = 8'h40;
    localparam logic [7:0] CLS_LOWER = 8'h24;
    localparam logic [7:0] CLS_DIGIT = 8'h23;
    localparam logic [7:0] CLS_DIGSP = 8'h7E;

    localparam logic [8*22-1:0] MASK_1123 = "## @$$ #### ##:##:## *";
    localparam logic [8*20-1:0] MASK_850  = "##-@$$-## ##:##:## *";
    localparam logic [8*21-1:0] MASK_ASC  = "@$$ ~# ##:##:## ####*";
    localparam logic [8*36-1:0] MONTH_NAMES = "JanFebMarAprMayJunJulAugSepOctNovDec";

    // Month indexes
    localparam logic [3:0] MON_JAN  = 4'd0;
    localparam logic [3:0] MON_FEB  = 4'd1;
    localparam logic [3:0] MON_MAR  = 4'd2;
    localparam logic [3:0] MON_APR  = 4'd3;
    localparam logic [3:0] MON_MAY  = 4'd4;
    localparam logic [3:0] MON_JUN  = 4'd5;
    localparam logic [3:0] MON_JUL  = 4'd6;
    localparam logic [3:0] MON_AUG  = 4'd7;
    localparam logic [3:0] MON_SEP  = 4'd8;
    localparam logic [3:0] MON_OCT  = 4'd9;
    localparam logic [3:0] MON_NOV  = 4'd10;
    localparam logic [3:0] MON_DEC  = 4'd11;
    localparam int         MONTHS   = 12;

    typedef enum logic [1:0] {
        FMT_1123 = 2'd0,
        FMT_850  = 2'd1,
        FMT_ASC  = 2'd2
    } fmt_t;

    typedef enum logic [3:0] {
        PH_SKIP_WS  = 4'b0001,
        PH_SKIP_DAY = 4'b0010,
        PH_COLLECT  = 4'b0100,
        PH_DEAD     = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        ST_SCAN   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        MS_DAYS  = 2'd0,
        MS_HOURS = 2'd1,
        MS_MINS  = 2'd2,
        MS_SECS  = 2'd3
    } mstep_t;

    // Mask character at a position of the checked part
    function automatic logic [7:0] mask_char(input fmt_t fmt, input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        ch = CH_END;
        unique case (fmt)
            FMT_1123: if (pos < POS_W'(LEN_1123)) ch = MASK_1123[8*(LEN_1123 - int'(pos)) +: 8];
            FMT_850:  if (pos < POS_W'(LEN_850))  ch = MASK_850[8*(LEN_850 - int'(pos)) +: 8];
            FMT_ASC:  if (pos < POS_W'(LEN_ASC))  ch = MASK_ASC[8*(LEN_ASC - int'(pos)) +: 8];
            default:  ch = CH_END;
        endcase
        return ch;
    endfunction

    // Byte against one mask character
    function automatic logic class_ok(input logic [7:0] m, input logic [7:0] b);
        logic dig;
        logic ok;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        unique case (m)
            CLS_UPPER: ok = (b >= CH_UP_A) && (b <= CH_UP_Z);
            CLS_LOWER: ok = (b >= CH_LO_A) && (b <= CH_LO_Z);
            CLS_DIGIT: ok = dig;
            CLS_DIGSP: ok = dig || (b == CH_SPACE);
            default:   ok = (m == b);
        endcase
        return ok;
    endfunction

    // Two ASCII digits to a number
    function automatic logic [6:0] dec2(input logic [7:0] hi, input logic [7:0] lo);
        return 7'({hi[3:0], 3'b000}) + 7'({hi[3:0], 1'b0}) + 7'(lo[3:0]);
    endfunction

    function automatic logic [23:0] month_name(input int idx);
        return MONTH_NAMES[24*(MONTHS - 1 - idx) +: 24];
    endfunction

    // Day of a March-based year on which each month starts
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] off;
        unique case (mon)
            MON_JAN: off = 9'd306;
            MON_FEB: off = 9'd337;
            MON_MAR: off = 9'd0;
            MON_APR: off = 9'd31;
            MON_MAY: off = 9'd61;
            MON_JUN: off = 9'd92;
            MON_JUL: off = 9'd122;
            MON_AUG: off = 9'd153;
            MON_SEP: off = 9'd184;
            MON_OCT: off = 9'd214;
            MON_NOV: off = 9'd245;
            MON_DEC: off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

[rtl/core/http_date_to_epoch_seconds.sv]
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// input     byte_valid / byte_ready      byte_in[7:0], last_byte
// output    result_valid / result_ready  epoch_seconds[37:0]
// config    cfg_write_en                 cfg_write_data (clamp to 32-bit time)
//
// Bytes are taken one per cycle while the string streams in.
// After the last byte the block drops byte_ready through the decode state, the check
// state, four multiply-add passes through the shared unit and the output load.
// The output load waits while a previous result is still held in the output register.
// Reset returns the scanner to whitespace skip and empties the output register.

module http_date_to_epoch_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [37:0] epoch_seconds,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data
);

    hde_pkg::state_t state_reg, state_next;
    hde_pkg::phase_t phase_reg, phase_next;
    hde_pkg::mstep_t step_reg, step_next;
    logic [hde_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [2:0]  flags_reg, flags_next;
    logic [7:0]  date_reg [hde_pkg::DATE_LEN];
    logic        clamp_reg;
    logic        result_valid_reg, result_valid_next;

    logic        byte_accept;
    logic [2:0]  byte_fail;
    logic        is_ws;

    // Decode stage
    hde_pkg::fmt_t fmt;
    logic        m1123, m850, masc, century_form;
    logic [6:0]  cc, yy;
    logic [23:0] mon_bytes;
    logic        ok_dec_reg, ok_dec_next;
    logic [6:0]  c_reg, c_next, r_reg, r_next;
    logic [6:0]  mday_reg, mday_next, hour_reg, hour_next;
    logic [6:0]  min_reg, min_next, sec_reg, sec_next;
    logic [3:0]  mon_reg, mon_next;
    logic        mon_found;

    // Check stage
    logic [hde_pkg::YEAR_W-1:0] year, yearm;
    logic        nonleap, short_month, early;
    logic [6:0]  cm, rm;
    logic        ok_reg, ok_next;
    logic [hde_pkg::SECS_W-1:0] base_reg, base_next;

    // Shared multiply-add unit
    logic [8:0]  mul_k;
    logic [hde_pkg::SECS_W-1:0] mul_add, mul_sum;
    logic [hde_pkg::SECS_W-1:0] acc_reg, acc_next;
    logic [hde_pkg::SECS_W-1:0] epoch_reg, epoch_next;
    logic        out_load;

    assign byte_ready    = (state_reg == hde_pkg::ST_SCAN);
    assign byte_accept   = byte_valid && byte_ready;
    assign result_valid  = result_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign out_load      = (state_reg == hde_pkg::ST_DONE) && (!result_valid_reg || result_ready);

    // Check the incoming byte against all three masks
    assign byte_fail[0] = (pos_reg < hde_pkg::POS_W'(hde_pkg::LEN_1123)) &&
        !hde_pkg::class_ok(hde_pkg::mask_char(hde_pkg::FMT_1123, pos_reg), byte_in);
    assign byte_fail[1] = (pos_reg < hde_pkg::POS_W'(hde_pkg::LEN_850)) &&
        !hde_pkg::class_ok(hde_pkg::mask_char(hde_pkg::FMT_850, pos_reg), byte_in);
    assign byte_fail[2] = (pos_reg < hde_pkg::POS_W'(hde_pkg::LEN_ASC)) &&
        !hde_pkg::class_ok(hde_pkg::mask_char(hde_pkg::FMT_ASC, pos_reg), byte_in);
    assign is_ws = (byte_in == hde_pkg::CH_SPACE) ||
        ((byte_in >= hde_pkg::CH_TAB) && (byte_in <= hde_pkg::CH_CR));

    // Advance the byte scanner; clear it once the date has been decoded
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        if (state_reg == hde_pkg::ST_DECODE)
        begin
            phase_next = hde_pkg::PH_SKIP_WS;
            pos_next   = '0;
            flags_next = 3'b111;
        end
        else if (byte_accept)
        begin
            unique case (phase_reg)
                hde_pkg::PH_SKIP_WS:
                begin
                    if (byte_in == hde_pkg::CH_NUL)
                    begin
                        flags_next = 3'b000;
                        phase_next = hde_pkg::PH_DEAD;
                    end
                    else if (!is_ws)
                    begin
                        phase_next = hde_pkg::PH_SKIP_DAY;
                    end
                end
                hde_pkg::PH_SKIP_DAY:
                begin
                    if (byte_in == hde_pkg::CH_SPACE)
                    begin
                        phase_next = hde_pkg::PH_COLLECT;
                    end
                    else if (byte_in == hde_pkg::CH_NUL)
                    begin
                        flags_next = 3'b000;
                        phase_next = hde_pkg::PH_DEAD;
                    end
                end
                hde_pkg::PH_COLLECT:
                begin
                    if (pos_reg < hde_pkg::POS_W'(hde_pkg::DATE_LEN))
                    begin
                        flags_next = flags_reg & ~byte_fail;
                        pos_next   = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Pick the first complete format and pull out its fields
    always_comb
    begin
        m1123 = flags_reg[0] && (pos_reg >= hde_pkg::POS_W'(hde_pkg::LEN_1123));
        m850  = flags_reg[1] && (pos_reg >= hde_pkg::POS_W'(hde_pkg::LEN_850));
        masc  = flags_reg[2] && (pos_reg >= hde_pkg::POS_W'(hde_pkg::LEN_ASC));
        priority if (m1123)
            fmt = hde_pkg::FMT_1123;
        else if (m850)
            fmt = hde_pkg::FMT_850;
        else
            fmt = hde_pkg::FMT_ASC;

        unique case (fmt)
            hde_pkg::FMT_850:
            begin
                century_form = 1'b0;
                cc        = '0;
                yy        = hde_pkg::dec2(date_reg[7], date_reg[8]);
                mday_next = hde_pkg::dec2(date_reg[0], date_reg[1]);
                hour_next = hde_pkg::dec2(date_reg[10], date_reg[11]);
                min_next  = hde_pkg::dec2(date_reg[13], date_reg[14]);
                sec_next  = hde_pkg::dec2(date_reg[16], date_reg[17]);
                mon_bytes = {date_reg[3], date_reg[4], date_reg[5]};
            end
            hde_pkg::FMT_ASC:
            begin
                century_form = 1'b1;
                cc        = hde_pkg::dec2(date_reg[16], date_reg[17]);
                yy        = hde_pkg::dec2(date_reg[18], date_reg[19]);
                mday_next = (date_reg[4] == hde_pkg::CH_SPACE) ? 7'(date_reg[5][3:0])
                                                              : hde_pkg::dec2(date_reg[4], date_reg[5]);
                hour_next = hde_pkg::dec2(date_reg[7], date_reg[8]);
                min_next  = hde_pkg::dec2(date_reg[10], date_reg[11]);
                sec_next  = hde_pkg::dec2(date_reg[13], date_reg[14]);
                mon_bytes = {date_reg[0], date_reg[1], date_reg[2]};
            end
            default:
            begin
                century_form = 1'b1;
                cc        = hde_pkg::dec2(date_reg[7], date_reg[8]);
                yy        = hde_pkg::dec2(date_reg[9], date_reg[10]);
                mday_next = hde_pkg::dec2(date_reg[0], date_reg[1]);
                hour_next = hde_pkg::dec2(date_reg[12], date_reg[13]);
                min_next  = hde_pkg::dec2(date_reg[15], date_reg[16]);
                sec_next  = hde_pkg::dec2(date_reg[18], date_reg[19]);
                mon_bytes = {date_reg[3], date_reg[4], date_reg[5]};
            end
        endcase

        // Split the year into centuries and remainder from 1900
        r_next = yy;
        if (century_form)
            c_next = cc - 7'(hde_pkg::MIN_CENT);
        else
            c_next = (yy < 7'(hde_pkg::MIN_YEAR)) ? 7'd1 : 7'd0;

        // Look up the month name
        mon_found = 1'b0;
        mon_next  = hde_pkg::MON_JAN;
        for (int i = 0; i < hde_pkg::MONTHS; i++)
        begin
            if (mon_bytes == hde_pkg::month_name(i))
            begin
                mon_found = 1'b1;
                mon_next  = 4'(i);
            end
        end

        ok_dec_next = (phase_reg == hde_pkg::PH_COLLECT) && (m1123 || m850 || masc) &&
                      mon_found && (!century_form || (cc >= 7'(hde_pkg::MIN_CENT)));
    end

    // Range checks, year and day base for the multiply passes
    always_comb
    begin
        year    = hde_pkg::YEAR_W'(c_reg) * hde_pkg::YEAR_W'(100) + hde_pkg::YEAR_W'(r_reg);
        nonleap = (r_reg[1:0] != 2'b00) || ((r_reg == 7'd0) && (c_reg[1:0] != 2'b01));
        short_month = (mon_reg == hde_pkg::MON_APR) || (mon_reg == hde_pkg::MON_JUN) ||
                      (mon_reg == hde_pkg::MON_SEP) || (mon_reg == hde_pkg::MON_NOV);
        early   = (mon_reg < hde_pkg::MON_MAR);

        ok_next = ok_dec_reg &&
                  (mday_reg != 7'd0) && (mday_reg <= 7'(hde_pkg::MAX_MDAY)) &&
                  (hour_reg <= 7'(hde_pkg::MAX_HOUR)) &&
                  (min_reg <= 7'(hde_pkg::MAX_MIN)) &&
                  (sec_reg <= 7'(hde_pkg::MAX_SEC)) &&
                  !(short_month && (mday_reg == 7'(hde_pkg::MAX_MDAY))) &&
                  !((mon_reg == hde_pkg::MON_FEB) &&
                    ((mday_reg > 7'(hde_pkg::LEAP_MDAY)) ||
                     ((mday_reg == 7'(hde_pkg::LEAP_MDAY)) && nonleap))) &&
                  (year >= hde_pkg::YEAR_W'(hde_pkg::MIN_YEAR)) &&
                  !(clamp_reg && (year >= hde_pkg::YEAR_W'(hde_pkg::CLAMP_YEAR)));

        // Count January and February with the year before
        cm = c_reg;
        rm = r_reg;
        if (early)
        begin
            if (r_reg == 7'd0)
            begin
                cm = c_reg - 7'd1;
                rm = 7'd99;
            end
            else
            begin
                rm = r_reg - 7'd1;
            end
        end
        yearm = year - hde_pkg::YEAR_W'(early);

        // Leap days of the full years, month start, day of month
        base_next = hde_pkg::SECS_W'({cm, 4'b0000}) + hde_pkg::SECS_W'({cm, 3'b000}) +
                    hde_pkg::SECS_W'(rm[6:2]) +
                    hde_pkg::SECS_W'((8'(cm) + 8'd3) >> 2) +
                    hde_pkg::SECS_W'(hde_pkg::month_offset(mon_reg)) +
                    hde_pkg::SECS_W'(mday_reg) -
                    hde_pkg::SECS_W'(hde_pkg::EPOCH_DAYS + 1);
    end

    // Shared multiply-add: acc * k + addend
    always_comb
    begin
        unique case (step_reg)
            hde_pkg::MS_DAYS:
            begin
                mul_k   = 9'd365;
                mul_add = base_reg;
            end
            hde_pkg::MS_HOURS:
            begin
                mul_k   = 9'd24;
                mul_add = hde_pkg::SECS_W'(hour_reg);
            end
            hde_pkg::MS_MINS:
            begin
                mul_k   = 9'd60;
                mul_add = hde_pkg::SECS_W'(min_reg);
            end
            default:
            begin
                mul_k   = 9'd60;
                mul_add = hde_pkg::SECS_W'(sec_reg);
            end
        endcase
        mul_sum = hde_pkg::SECS_W'(acc_reg * hde_pkg::SECS_W'(mul_k)) + mul_add;
    end

    // Sequence the conversion and hold the result until taken
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        acc_next          = (state_reg == hde_pkg::ST_CHECK) ? hde_pkg::SECS_W'(yearm) : mul_sum;
        epoch_next        = ok_reg ? acc_reg : '0;
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;
        unique case (state_reg)
            hde_pkg::ST_SCAN:
            begin
                if (byte_accept && last_byte)
                    state_next = hde_pkg::ST_DECODE;
            end
            hde_pkg::ST_DECODE:
            begin
                state_next = hde_pkg::ST_CHECK;
            end
            hde_pkg::ST_CHECK:
            begin
                state_next = hde_pkg::ST_MUL;
                step_next  = hde_pkg::MS_DAYS;
            end
            hde_pkg::ST_MUL:
            begin
                if (step_reg == hde_pkg::MS_SECS)
                    state_next = hde_pkg::ST_DONE;
                else
                    step_next = hde_pkg::mstep_t'(step_reg + 2'd1);
            end
            hde_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    result_valid_next = 1'b1;
                    state_next        = hde_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = hde_pkg::ST_SCAN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hde_pkg::ST_SCAN;
            phase_reg        <= hde_pkg::PH_SKIP_WS;
            step_reg         <= hde_pkg::MS_DAYS;
            pos_reg          <= '0;
            flags_reg        <= 3'b111;
            clamp_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            step_reg         <= step_next;
            pos_reg          <= pos_next;
            flags_reg        <= flags_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
                clamp_reg <= cfg_write_data;
        end
    end

    // Date bytes and datapath registers
    always_ff @(posedge clk)
    begin
        if (byte_accept && (phase_reg == hde_pkg::PH_COLLECT) &&
            (pos_reg < hde_pkg::POS_W'(hde_pkg::DATE_LEN)))
            date_reg[pos_reg] <= byte_in;
        if (state_reg == hde_pkg::ST_DECODE)
        begin
            ok_dec_reg <= ok_dec_next;
            c_reg      <= c_next;
            r_reg      <= r_next;
            mday_reg   <= mday_next;
            hour_reg   <= hour_next;
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            mon_reg    <= mon_next;
        end
        if (state_reg == hde_pkg::ST_CHECK)
        begin
            ok_reg   <= ok_next;
            base_reg <= base_next;
        end
        if ((state_reg == hde_pkg::ST_CHECK) || (state_reg == hde_pkg::ST_MUL))
            acc_reg <= acc_next;
        if (out_load)
            epoch_reg <= epoch_next;
    end

endmodule

[dv/http_date_to_epoch_seconds_tb.sv]
`timescale 1ns / 1ps

module http_date_to_epoch_seconds_tb;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          END_CYCLES    = 20;
    localparam int          REPORT_MAX    = 10;
    localparam int          DATE_BYTES    = 21;

    // Calendar constants: years counted from 1900, days from a March-based year
    localparam longint      FIRST_CENTURY = 19;
    localparam longint      FIRST_YEAR    = 70;
    localparam longint      CLAMP_YEAR    = 138;
    localparam longint      EPOCH_DAY     = 25508;

    localparam logic [7:0]  ASCII_NUL     = 8'h00;
    localparam logic [7:0]  ASCII_TAB     = 8'h09;
    localparam logic [7:0]  ASCII_CR      = 8'h0D;
    localparam logic [7:0]  ASCII_SPACE   = 8'h20;

    // Mask character classes
    localparam logic [7:0]  CLS_UPPER     = "@";
    localparam logic [7:0]  CLS_LOWER     = "$";
    localparam logic [7:0]  CLS_DIGIT     = "#";
    localparam logic [7:0]  CLS_DIGSP     = "~";

    typedef enum int {SCAN_WS, SCAN_WEEKDAY, SCAN_DATE, SCAN_DEAD} scan_t;
    typedef enum int {FMT_RFC1123, FMT_RFC850, FMT_ASCTIME} date_fmt_t;
    typedef enum int {
        M_JAN, M_FEB, M_MAR, M_APR, M_MAY, M_JUN,
        M_JUL, M_AUG, M_SEP, M_OCT, M_NOV, M_DEC, M_NONE
    } month_t;

    string mask_rfc1123 = "## @$$ #### ##:##:## *";
    string mask_rfc850  = "##-@$$-## ##:##:## *";
    string mask_asctime = "@$$ ~# ##:##:## ####*";
    string month_abbr   = "JanFebMarAprMayJunJulAugSepOctNovDec";
    string weekday_abbr = "SunMonTueWedThuFriSat";

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        byte_valid     = 1'b0;
    logic        byte_ready;
    logic [7:0]  byte_in        = 8'h00;
    logic        last_byte      = 1'b0;
    logic        result_valid;
    logic        result_ready   = 1'b0;
    logic [37:0] epoch_seconds;
    logic        cfg_write_en   = 1'b0;
    logic        cfg_write_data = 1'b0;

    // Parser mirror
    scan_t       scan_state = SCAN_WS;
    int          date_pos   = 0;
    logic [2:0]  fmt_alive  = 3'b111;
    logic [7:0]  date_buf [DATE_BYTES];
    bit          clamp_32bit = 1'b0;

    logic [37:0] pending_epochs [$];
    logic [7:0]  stream_buf [$];

    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          cycle_count     = 0;
    int          mismatch_count  = 0;
    int          bytes_sent      = 0;
    int          strings_sent    = 0;
    int          results_checked = 0;
    int          valid_dates     = 0;

    http_date_to_epoch_seconds u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_in       (byte_in),
        .last_byte     (last_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .epoch_seconds (epoch_seconds),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser mirror
    // ------------------------------------------------------------------

    function automatic string mask_for(input date_fmt_t f);
        case (f)
            FMT_RFC1123: return mask_rfc1123;
            FMT_RFC850:  return mask_rfc850;
            default:     return mask_asctime;
        endcase
    endfunction

    // The trailing end marker is not part of the checked bytes
    function automatic int checked_len(input date_fmt_t f);
        string m;
        m = mask_for(f);
        return m.len() - 1;
    endfunction

    function automatic bit char_fits(input logic [7:0] m, input logic [7:0] b);
        bit dig;
        dig = (b >= "0") && (b <= "9");
        case (m)
            CLS_UPPER: return (b >= "A") && (b <= "Z");
            CLS_LOWER: return (b >= "a") && (b <= "z");
            CLS_DIGIT: return dig;
            CLS_DIGSP: return dig || (b == ASCII_SPACE);
            default:   return m == b;
        endcase
    endfunction

    function automatic longint digit_at(input int i);
        return longint'(date_buf[i]) - 48;
    endfunction

    function automatic logic [37:0] date_to_seconds();
        longint year, mday, hours, mins, secs_f, days, total;
        int     f, hit, mon_at, time_at, m, march_idx;
        month_t mon;
        hit = -1;
        for (f = 0; f < 3; f++)
            if (hit < 0 && fmt_alive[f] && date_pos >= checked_len(date_fmt_t'(f)))
                hit = f;
        if (hit < 0)
            return '0;
        // Pull year, day and field positions from the matched layout
        case (date_fmt_t'(hit))
            FMT_RFC1123:
            begin
                year = (digit_at(7) * 10 + digit_at(8) - FIRST_CENTURY) * 100;
                if (year < 0)
                    return '0;
                year += digit_at(9) * 10 + digit_at(10);
                mday = digit_at(0) * 10 + digit_at(1);
                mon_at = 3;
                time_at = 12;
            end
            FMT_RFC850:
            begin
                year = digit_at(7) * 10 + digit_at(8);
                if (year < FIRST_YEAR)
                    year += 100;
                mday = digit_at(0) * 10 + digit_at(1);
                mon_at = 3;
                time_at = 10;
            end
            default:
            begin
                year = (digit_at(16) * 10 + digit_at(17) - FIRST_CENTURY) * 100;
                if (year < 0)
                    return '0;
                year += digit_at(18) * 10 + digit_at(19);
                mday = (date_buf[4] == ASCII_SPACE) ? 0 : digit_at(4) * 10;
                mday += digit_at(5);
                mon_at = 0;
                time_at = 7;
            end
        endcase
        if (mday <= 0 || mday > 31)
            return '0;
        hours  = digit_at(time_at) * 10 + digit_at(time_at + 1);
        mins   = digit_at(time_at + 3) * 10 + digit_at(time_at + 4);
        secs_f = digit_at(time_at + 6) * 10 + digit_at(time_at + 7);
        if (hours > 23 || mins > 59 || secs_f > 61)
            return '0;
        mon = M_NONE;
        for (m = 11; m >= 0; m--)
            if (date_buf[mon_at] == month_abbr[3 * m] &&
                date_buf[mon_at + 1] == month_abbr[3 * m + 1] &&
                date_buf[mon_at + 2] == month_abbr[3 * m + 2])
                mon = month_t'(m);
        if (mon == M_NONE)
            return '0;
        if (mday == 31 && (mon == M_APR || mon == M_JUN || mon == M_SEP || mon == M_NOV))
            return '0;
        if (mon == M_FEB && (mday > 29 ||
            (mday == 29 && ((year % 4) != 0 || (year % 100 == 0 && year % 400 != 100)))))
            return '0;
        if (year < FIRST_YEAR || (clamp_32bit && year >= CLAMP_YEAR))
            return '0;
        // January and February belong to the previous March-based year
        if (mon == M_JAN || mon == M_FEB)
            year--;
        march_idx = (int'(mon) + 10) % 12;
        days = year * 365 + year / 4 - year / 100 + (year / 100 + 3) / 4;
        days += (153 * march_idx + 2) / 5 + mday - 1 - EPOCH_DAY;
        total = ((days * 24 + hours) * 60 + mins) * 60 + secs_f;
        if (total < 0)
            return '0;
        return total[37:0];
    endfunction

    function automatic void advance_parser(input logic [7:0] b, input bit last,
                                           output bit has_result, output logic [37:0] secs);
        int    f;
        string mask;
        case (scan_state)
            SCAN_WS:
            begin
                if (b == ASCII_NUL)
                begin
                    fmt_alive = '0;
                    scan_state = SCAN_DEAD;
                end
                else if (!(b == ASCII_SPACE || (b >= ASCII_TAB && b <= ASCII_CR)))
                    scan_state = SCAN_WEEKDAY;
            end
            SCAN_WEEKDAY:
            begin
                if (b == ASCII_SPACE)
                    scan_state = SCAN_DATE;
                else if (b == ASCII_NUL)
                begin
                    fmt_alive = '0;
                    scan_state = SCAN_DEAD;
                end
            end
            SCAN_DATE:
            begin
                if (date_pos < DATE_BYTES)
                begin
                    date_buf[date_pos] = b;
                    for (f = 0; f < 3; f++)
                    begin
                        mask = mask_for(date_fmt_t'(f));
                        if (date_pos < checked_len(date_fmt_t'(f)))
                            if (!char_fits(mask.getc(date_pos), b))
                                fmt_alive[f] = 1'b0;
                    end
                    date_pos++;
                end
            end
            default:
            begin
            end
        endcase
        has_result = last;
        secs = '0;
        if (last)
        begin
            if (scan_state == SCAN_DATE)
                secs = date_to_seconds();
            scan_state = SCAN_WS;
            date_pos = 0;
            fmt_alive = 3'b111;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, pending_epochs.size());
            $display("status: fail");
            $finish;
        end
    end

    // Compare each result transaction with the oldest predicted epoch
    always @(posedge clk)
    begin
        logic [37:0] want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_epochs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: epoch_seconds %0d", epoch_seconds);
            end
            else
            begin
                want = pending_epochs.pop_front();
                results_checked++;
                if (want != 0)
                    valid_dates++;
                if (epoch_seconds !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch on result %0d: expected %0d, got %0d",
                                 results_checked, want, epoch_seconds);
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input bit last);
        bit          has_result;
        logic [37:0] secs;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_in    <= b;
        last_byte  <= last;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        advance_parser(b, last, has_result, secs);
        if (has_result)
            pending_epochs.push_back(secs);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_buf.size(); i++)
            send_byte(stream_buf[i], i == stream_buf.size() - 1);
        strings_sent++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            stream_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        stream_buf.delete();
        put_text(s);
        send_stream();
    endtask

    // Send a string with a NUL byte between two halves
    task automatic send_with_nul(input string head, input string tail);
        stream_buf.delete();
        put_text(head);
        stream_buf.push_back(ASCII_NUL);
        put_text(tail);
        send_stream();
    endtask

    // Hold the sender until every result is back, then let the block settle
    task automatic wait_until_idle(input int settle);
        byte_valid <= 1'b0;
        while (pending_epochs.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_clamp(input bit value);
        wait_until_idle(SETTLE_CYCLES);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        clamp_32bit = value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic string random_month_text();
        int    r, m;
        string s;
        r = $urandom_range(99);
        m = $urandom_range(11);
        s = month_abbr.substr(3 * m, 3 * m + 2);
        if (r < 6)
        begin
            // Right shape, unknown name
            s.putc(0, 8'($urandom_range("Z", "A")));
            s.putc(1, 8'($urandom_range("z", "a")));
            s.putc(2, 8'($urandom_range("z", "a")));
        end
        else if (r < 9)
            s.putc(0, s[0] + 8'h20);
        return s;
    endfunction

    function automatic string random_date_text(input date_fmt_t f);
        int    r, year, mday, hh, mm, ss;
        string mtxt;
        r = $urandom_range(99);
        if (f == FMT_RFC850)
            year = $urandom_range(99);
        else if (r < 55)
            year = $urandom_range(2100, 1970);
        else if (r < 75)
            year = $urandom_range(2045, 2030);
        else if (r < 85)
            year = $urandom_range(1969, 1850);
        else
            year = $urandom_range(9999);
        mtxt = random_month_text();
        r = $urandom_range(99);
        if (r < 75)
            mday = $urandom_range(31, 1);
        else if (r < 90)
        begin
            mday = $urandom_range(31, 28);
            if ($urandom_range(1))
                mtxt = "Feb";
        end
        else
            mday = $urandom_range(1) ? 0 : $urandom_range(39, 32);
        if ($urandom_range(99) < 90)
        begin
            hh = $urandom_range(23);
            mm = $urandom_range(59);
            ss = $urandom_range(61);
        end
        else
        begin
            hh = $urandom_range(99);
            mm = $urandom_range(99);
            ss = $urandom_range(99);
        end
        case (f)
            FMT_RFC1123:
                return $sformatf("%02d %s %04d %02d:%02d:%02d GMT",
                                 mday, mtxt, year, hh, mm, ss);
            FMT_RFC850:
                return $sformatf("%02d-%s-%02d %02d:%02d:%02d GMT",
                                 mday, mtxt, year, hh, mm, ss);
            default:
                return $sformatf("%s %2d %02d:%02d:%02d %04d",
                                 mtxt, mday, hh, mm, ss, year);
        endcase
    endfunction

    // Leading whitespace, a weekday token or random non-space bytes, and the separating space
    task automatic put_prefix();
        int i, n, d;
        n = $urandom_range(2);
        for (i = 0; i < n; i++)
            stream_buf.push_back($urandom_range(1) ? ASCII_SPACE
                                                   : 8'($urandom_range(ASCII_CR, ASCII_TAB)));
        if ($urandom_range(99) < 70)
        begin
            d = $urandom_range(6);
            put_text(weekday_abbr.substr(3 * d, 3 * d + 2));
            if ($urandom_range(1))
                put_text(",");
        end
        else
        begin
            n = $urandom_range(8, 1);
            for (i = 0; i < n; i++)
                stream_buf.push_back(8'($urandom_range(8'hFF, 8'h21)));
        end
        stream_buf.push_back(ASCII_SPACE);
    endtask

    task automatic send_random_string();
        int kind, i, n;
        kind = $urandom_range(99);
        stream_buf.delete();
        if (kind < 8)
        begin
            // Raw noise of any byte value
            n = $urandom_range(40, 1);
            for (i = 0; i < n; i++)
                stream_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            put_prefix();
            put_text(random_date_text(date_fmt_t'($urandom_range(2))));
            if (kind < 14)
            begin
                n = $urandom_range(stream_buf.size(), 1);
                while (stream_buf.size() > n)
                    void'(stream_buf.pop_back());
            end
            else if (kind < 20)
                stream_buf[$urandom_range(stream_buf.size() - 1)] = 8'($urandom_range(255));
            else if (kind < 23)
                stream_buf.insert($urandom_range(stream_buf.size() - 1), ASCII_NUL);
        end
        send_stream();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reference_formats();
        send_text("Sun, 06 Nov 1994 08:49:37 GMT");
        send_text("Sunday, 06-Nov-94 08:49:37 GMT");
        send_text("Sun Nov  6 08:49:37 1994");
        send_text("\040\011\012\013\014\015Thu, 01 Jan 1970 00:00:01 GMT");
        send_text("Thu, 01 Jan 1970 00:00:00 GMT");
        send_text("Wed, 31 Dec 1969 23:59:59 GMT");
        send_text("Fri, 31 Dec 9999 23:59:59 GMT");
    endtask

    task automatic test_field_limits();
        send_text("Mon, 01 Jan 1899 00:00:00 GMT");
        send_text("Tue, 01-Jan-69 00:00:00 GMT");
        send_text("Thu, 01-Jan-70 00:00:01 GMT");
        send_text("Tue, 29 Feb 2000 12:00:00 GMT");
        send_text("Mon, 29 Feb 2100 12:00:00 GMT");
        send_text("Wed, 29 Feb 2023 12:00:00 GMT");
        send_text("Sat Feb 30 00:00:00 2024");
        send_text("Thu, 31 Apr 2020 00:00:00 GMT");
        send_text("Fri, 31-Dec-99 24:00:00 GMT");
        send_text("Sat, 31 Dec 2016 23:60:00 GMT");
        send_text("Sat, 31 Dec 2016 23:59:61 GMT");
        send_text("Sat, 31 Dec 2016 23:59:62 GMT");
        send_text("Sun, 00 Jan 2000 00:00:00 GMT");
        send_text("Sun, 32 Jan 2000 00:00:00 GMT");
        send_text("Sun Jan  0 00:00:00 2000");
    endtask

    task automatic test_malformed_strings();
        send_text("Sun, 06 Nov 1994 08:49");
        send_text("Sun, 06 Xyz 1994 08:49:37 GMT");
        send_text("Sun, 06 nov 1994 08:49:37 GMT");
        send_text("Sunday");
        send_text("\011 ");
        send_with_nul("Sun", ", 06 Nov 1994 08:49:37 GMT");
        send_with_nul("Sun, 06 Nov 19", "94 08:49:37 GMT");
        send_with_nul("", "");
        send_text("\377\200, 06 Nov 1994 08:49:37 GMT\377");
    endtask

    task automatic test_clamp_2038();
        set_clamp(1'b1);
        send_text("Thu, 31 Dec 2037 23:59:59 GMT");
        send_text("Tue, 19 Jan 2038 03:14:07 GMT");
        send_text("Fri, 01-Jan-38 00:00:00 GMT");
        set_clamp(1'b0);
        send_text("Tue, 19 Jan 2038 03:14:07 GMT");
        send_text("Fri, 01-Jan-38 00:00:00 GMT");
    endtask

    // One traffic mix: drain, set the clamp, then random strings
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input bit clamp);
        int start_bytes;
        set_clamp(clamp);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_bytes    = bytes_sent;
        while (bytes_sent - start_bytes < 125)
            send_random_string();
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reference_formats();
        test_field_limits();
        test_malformed_strings();
        test_clamp_2038();

        test_random_traffic(0, 0, 1'b0);
        test_random_traffic(61, 0, 1'b1);
        test_random_traffic(0, 61, 1'b0);
        test_random_traffic(24, 24, 1'b1);

        wait_until_idle(END_CYCLES);

        $display("sent %0d date strings (%0d bytes) in four idle/stall mixes, clamp on and off",
                 strings_sent, bytes_sent);
        $display("checked %0d results, %0d of them valid dates, %0d mismatches",
                 results_checked, valid_dates, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[http_date_to_epoch_seconds.f]
rtl/core/hde_pkg.sv
rtl/core/http_date_to_epoch_seconds.sv
dv/http_date_to_epoch_seconds_tb.sv
